FILE: hdl/rcpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_pkg
// shared widths, register codes and reset values for the rc pwm capture block
// ----------------------------------------------------------------------------
package rcpa_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int NUM_CHANNELS_DEF  = 5;
    localparam int CH_W_MIN          = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THROTTLE_ARM_MIN    = 2'd0,
        CFG_THROTTLE_OFFSET_MIN = 2'd1,
        CFG_STICK_LOW_MAX       = 2'd2,
        CFG_STICK_HIGH_MIN      = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_DATA_W-1:0] RST_THROTTLE_ARM_MIN    = 16'd8000;
    localparam logic [CFG_DATA_W-1:0] RST_THROTTLE_OFFSET_MIN = 16'd8200;
    localparam logic [CFG_DATA_W-1:0] RST_STICK_LOW_MAX       = 16'd8300;
    localparam logic [CFG_DATA_W-1:0] RST_STICK_HIGH_MIN      = 16'd14600;

    localparam int CH_ROLL     = 0;
    localparam int CH_PITCH    = 1;
    localparam int CH_THROTTLE = 2;

    // channel field width: at least three bits, more when the channel count needs it
    function automatic int ch_width(input int num_channels);
        int w;
        w = $clog2(num_channels);
        return (w > CH_W_MIN) ? w : CH_W_MIN;
    endfunction

endpackage

FILE: hdl/rcpa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_in_if
// edge capture event channel: channel number, counter value, pin level
// ----------------------------------------------------------------------------
interface rcpa_in_if #(
    parameter int CH_W  = rcpa_pkg::CH_W_MIN,
    parameter int CNT_W = rcpa_pkg::COUNTER_WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel;
    logic [CNT_W-1:0] capture_value;
    logic             pin_level;

    modport source (output valid, output channel, output capture_value,
                    output pin_level, input ready);
    modport sink   (input valid, input channel, input capture_value,
                    input pin_level, output ready);
endinterface

FILE: hdl/rcpa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_out_if
// result channel: echoed channel, measured width and arming status
// ----------------------------------------------------------------------------
interface rcpa_out_if #(
    parameter int CH_W  = rcpa_pkg::CH_W_MIN,
    parameter int CNT_W = rcpa_pkg::COUNTER_WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel_echo;
    logic             width_valid;
    logic [CNT_W-1:0] pulse_width;
    logic             armed;
    logic             offset_request;

    modport source (output valid, output channel_echo, output width_valid,
                    output pulse_width, output armed, output offset_request,
                    input ready);
    modport sink   (input valid, input channel_echo, input width_valid,
                    input pulse_width, input armed, input offset_request,
                    output ready);
endinterface

FILE: hdl/rcpa_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpa_cfg_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface rcpa_cfg_if;
    import rcpa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/rc_pwm_capture_arming.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pwm_capture_arming
// rc receiver pulse width capture with stick gesture arming
// ----------------------------------------------------------------------------
// Each input item is one edge capture event (channel, counter value at the
// edge, pin level after it). A falling edge yields the pulse width as the
// counter difference to that channel's previous edge, modulo 2^COUNTER_WIDTH.
// After every item the roll, pitch and throttle widths, including the one
// just measured, are checked against the four threshold registers to set or
// clear armed and to flag an offset request. The block takes one item per
// clock unless stalled; its result is in the output register in the cycle
// after the item is taken, and a new item is taken in the same cycle the held
// result is taken. Edge times and widths live in a small per-channel register
// file written and read in the same cycle, which sets the one-item-per-clock
// figure. The configuration port is always ready. Channels at or above
// NUM_CHANNELS leave per-channel state alone but still produce a result.
// ----------------------------------------------------------------------------
module rc_pwm_capture_arming #(
    parameter int COUNTER_WIDTH = rcpa_pkg::COUNTER_WIDTH_DEF,
    parameter int NUM_CHANNELS  = rcpa_pkg::NUM_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rcpa_in_if.sink     i_in,
    rcpa_out_if.source  o_out,
    rcpa_cfg_if.sink    i_cfg
);
    import rcpa_pkg::*;

    localparam int CH_W     = ch_width(NUM_CHANNELS);
    localparam int CH_IDX_W = $clog2(NUM_CHANNELS);
    localparam int CMP_W    = (COUNTER_WIDTH > CFG_DATA_W) ? COUNTER_WIDTH : CFG_DATA_W;

    // threshold registers
    logic [CFG_DATA_W-1:0] r_thr_arm_min;
    logic [CFG_DATA_W-1:0] r_thr_offset_min;
    logic [CFG_DATA_W-1:0] r_stick_low_max;
    logic [CFG_DATA_W-1:0] r_stick_high_min;

    // per-channel state
    logic [COUNTER_WIDTH-1:0] r_last_edge [NUM_CHANNELS];
    logic [COUNTER_WIDTH-1:0] r_ch_width  [NUM_CHANNELS];
    logic                     r_armed;

    // output register
    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out_channel;
    logic                     r_out_width_valid;
    logic [COUNTER_WIDTH-1:0] r_out_width;
    logic                     r_out_armed;
    logic                     r_out_offset;

    logic                     w_in_fire;
    logic                     w_ch_ok;
    logic [CH_IDX_W-1:0]      w_idx;
    logic                     w_meas;
    logic [COUNTER_WIDTH-1:0] w_width;
    logic [CMP_W-1:0]         w_roll;
    logic [CMP_W-1:0]         w_pitch;
    logic [CMP_W-1:0]         w_thr;
    logic [CMP_W-1:0]         w_arm_min;
    logic [CMP_W-1:0]         w_offset_min;
    logic [CMP_W-1:0]         w_low_max;
    logic [CMP_W-1:0]         w_high_min;
    logic                     w_arm;
    logic                     w_disarm;
    logic                     w_offset;
    logic                     n_armed;

    // ------------------------------------------------------------------------
    // handshakes: take an item when the output register is free or draining
    // ------------------------------------------------------------------------
    assign i_in.ready  = i_rst_n && (!r_out_valid || o_out.ready);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // ------------------------------------------------------------------------
    // width measurement
    // ------------------------------------------------------------------------
    assign w_ch_ok = 32'(i_in.channel) < NUM_CHANNELS;
    assign w_idx   = i_in.channel[CH_IDX_W-1:0];
    assign w_meas  = w_ch_ok && !i_in.pin_level;
    assign w_width = i_in.capture_value - r_last_edge[w_idx];

    // ------------------------------------------------------------------------
    // gesture check on the widths as they stand after this item
    // ------------------------------------------------------------------------
    always_comb begin
        w_roll  = CMP_W'(r_ch_width[CH_ROLL]);
        w_pitch = CMP_W'(r_ch_width[CH_PITCH]);
        w_thr   = CMP_W'(r_ch_width[CH_THROTTLE]);
        // bypass the width written by this very item
        if (w_meas && (w_idx == CH_IDX_W'(CH_ROLL))) begin
            w_roll = CMP_W'(w_width);
        end
        if (w_meas && (w_idx == CH_IDX_W'(CH_PITCH))) begin
            w_pitch = CMP_W'(w_width);
        end
        if (w_meas && (w_idx == CH_IDX_W'(CH_THROTTLE))) begin
            w_thr = CMP_W'(w_width);
        end
    end

    assign w_arm_min    = CMP_W'(r_thr_arm_min);
    assign w_offset_min = CMP_W'(r_thr_offset_min);
    assign w_low_max    = CMP_W'(r_stick_low_max);
    assign w_high_min   = CMP_W'(r_stick_high_min);

    assign w_arm    = (w_thr > w_arm_min) && (w_thr < w_low_max)
                   && (w_pitch < w_low_max) && (w_roll < w_low_max);
    assign w_offset = (w_thr > w_offset_min) && (w_thr < w_low_max)
                   && (w_pitch > w_high_min) && (w_roll > w_high_min);
    assign w_disarm = (w_thr < w_low_max) && (w_pitch < w_low_max)
                   && (w_roll > w_high_min);

    // disarm wins over arm
    always_comb begin
        n_armed = r_armed;
        if (w_arm) begin
            n_armed = 1'b1;
        end
        if (w_disarm) begin
            n_armed = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_arm_min    <= RST_THROTTLE_ARM_MIN;
            r_thr_offset_min <= RST_THROTTLE_OFFSET_MIN;
            r_stick_low_max  <= RST_STICK_LOW_MAX;
            r_stick_high_min <= RST_STICK_HIGH_MIN;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_THROTTLE_ARM_MIN:    r_thr_arm_min    <= i_cfg.data;
                CFG_THROTTLE_OFFSET_MIN: r_thr_offset_min <= i_cfg.data;
                CFG_STICK_LOW_MAX:       r_stick_low_max  <= i_cfg.data;
                CFG_STICK_HIGH_MIN:      r_stick_high_min <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // per-channel state and armed flag
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_last_edge[k] <= '0;
                r_ch_width[k]  <= '0;
            end
            r_armed <= 1'b0;
        end else if (w_in_fire) begin
            if (w_ch_ok) begin
                r_last_edge[w_idx] <= i_in.capture_value;
            end
            if (w_meas) begin
                r_ch_width[w_idx] <= w_width;
            end
            r_armed <= n_armed;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out_channel     <= i_in.channel;
            r_out_width_valid <= w_meas;
            r_out_width       <= w_meas ? w_width : '0;
            r_out_armed       <= n_armed;
            r_out_offset      <= w_offset;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.channel_echo   = r_out_channel;
    assign o_out.width_valid    = r_out_width_valid;
    assign o_out.pulse_width    = r_out_width;
    assign o_out.armed          = r_out_armed;
    assign o_out.offset_request = r_out_offset;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty output register");

    a_width_only_on_fall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (o_out.width_valid == (!$past(i_in.pin_level)
                        && (32'($past(i_in.channel)) < NUM_CHANNELS))))
        else $error("width_valid does not match edge and channel");

    a_zero_width_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.width_valid) |-> (o_out.pulse_width == '0))
        else $error("pulse width nonzero without a measurement");

    a_armed_tracks_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (o_out.armed == r_armed))
        else $error("reported armed differs from armed flag");

    a_arm_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_armed) |-> $past(w_in_fire))
        else $error("armed flag set without an item");

endmodule

FILE: bench/rc_pwm_capture_arming_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pwm_capture_arming_tb
// self-checking bench for the rc pulse capture and stick gesture arming block
// ----------------------------------------------------------------------------
// Edge events are pushed through the input channel with random gaps while the
// result channel stalls at random. A scoreboard keeps its own copy of the
// per-channel edge times, widths, arming flag and thresholds, predicts each
// result when the event is taken and compares it field by field when the
// result is taken. A short directed run covers wrap, equal captures, ignored
// channels and the arm, disarm and offset gestures; random phases follow under
// several threshold settings, extremes included.
// ----------------------------------------------------------------------------
module rc_pwm_capture_arming_tb;
    import rcpa_pkg::*;

    class capture_arming_scoreboard #(
        int CH_W  = CH_W_MIN,
        int CNT_W = COUNTER_WIDTH_DEF,
        int NCH   = NUM_CHANNELS_DEF
    );
        typedef struct {
            logic [CH_W-1:0]  channel_echo;
            logic             width_valid;
            logic [CNT_W-1:0] pulse_width;
            logic             armed;
            logic             offset_request;
        } t_reading;

        logic [CNT_W-1:0]      edge_time   [NCH];
        logic [CNT_W-1:0]      width_store [NCH];
        logic                  armed_now;
        logic [CFG_DATA_W-1:0] cfg_reg     [4];
        t_reading              pending_readings [$];
        int                    mismatches;

        function new();
            for (int i = 0; i < NCH; i++) begin
                edge_time[i]   = '0;
                width_store[i] = '0;
            end
            armed_now = 1'b0;
            cfg_reg[CFG_THROTTLE_ARM_MIN]    = RST_THROTTLE_ARM_MIN;
            cfg_reg[CFG_THROTTLE_OFFSET_MIN] = RST_THROTTLE_OFFSET_MIN;
            cfg_reg[CFG_STICK_LOW_MAX]       = RST_STICK_LOW_MAX;
            cfg_reg[CFG_STICK_HIGH_MIN]      = RST_STICK_HIGH_MIN;
            mismatches = 0;
        endfunction

        function void write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
            cfg_reg[idx] = val;
        endfunction

        // event taken by the block: update the shadow state and queue its result
        function void note_event(input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] cap,
                                 input logic pin);
            t_reading         r;
            logic [CNT_W-1:0] roll;
            logic [CNT_W-1:0] pitch;
            logic [CNT_W-1:0] thr;
            logic [CNT_W-1:0] low;
            logic [CNT_W-1:0] high;
            r.channel_echo   = ch;
            r.width_valid    = 1'b0;
            r.pulse_width    = '0;
            if (ch < NCH) begin
                if (!pin) begin
                    r.pulse_width   = cap - edge_time[ch];
                    width_store[ch] = r.pulse_width;
                    r.width_valid   = 1'b1;
                end
                edge_time[ch] = cap;
            end
            roll  = width_store[CH_ROLL];
            pitch = width_store[CH_PITCH];
            thr   = width_store[CH_THROTTLE];
            low   = cfg_reg[CFG_STICK_LOW_MAX];
            high  = cfg_reg[CFG_STICK_HIGH_MIN];
            if (thr > cfg_reg[CFG_THROTTLE_ARM_MIN] && thr < low && pitch < low && roll < low)
                armed_now = 1'b1;
            r.offset_request = (thr > cfg_reg[CFG_THROTTLE_OFFSET_MIN] && thr < low &&
                                pitch > high && roll > high);
            // disarm goes last so it wins over arm
            if (thr < low && pitch < low && roll > high)
                armed_now = 1'b0;
            r.armed = armed_now;
            pending_readings.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] exp_v,
                                    input logic [31:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s expected %0d got %0d", name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_result(input logic [CH_W-1:0] ch_echo, input logic w_valid,
                                   input logic [CNT_W-1:0] width, input logic armed,
                                   input logic offset);
            t_reading exp_r;
            if (pending_readings.size() == 0) begin
                $error("result with no event pending, channel_echo %0d", ch_echo);
                mismatches++;
                return;
            end
            exp_r = pending_readings.pop_front();
            compare_field("channel_echo", 32'(exp_r.channel_echo), 32'(ch_echo));
            compare_field("width_valid", 32'(exp_r.width_valid), 32'(w_valid));
            compare_field("pulse_width", 32'(exp_r.pulse_width), 32'(width));
            compare_field("armed", 32'(exp_r.armed), 32'(armed));
            compare_field("offset_request", 32'(exp_r.offset_request), 32'(offset));
        endfunction
    endclass

    localparam int CNT_W       = COUNTER_WIDTH_DEF;
    localparam int NCH         = NUM_CHANNELS_DEF;
    localparam int CH_W        = ch_width(NCH);
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 122;   // random events per threshold setting
    localparam int HOLD_CYCLES = 150;   // long result-side stall
    localparam int DRAIN_TAIL  = 8;     // settle cycles after the last result

    logic i_clk = 1'b0;
    logic i_rst_n;

    // idling switches, flipped per phase so some stretches run back to back
    bit in_idle  = 1'b1;
    bit out_idle = 1'b1;
    // set by the stimulus to make the result side hold off once
    bit hold_req = 1'b0;

    capture_arming_scoreboard #(CH_W, CNT_W, NCH) sb;

    rcpa_in_if  #(.CH_W(CH_W), .CNT_W(CNT_W)) in_if ();
    rcpa_out_if #(.CH_W(CH_W), .CNT_W(CNT_W)) out_if ();
    rcpa_cfg_if                               cfg_if ();

    rc_pwm_capture_arming #(
        .COUNTER_WIDTH (CNT_W),
        .NUM_CHANNELS  (NCH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    always #6 i_clk = ~i_clk;

    // --------------------------------------------------------------------
    // input side
    // --------------------------------------------------------------------

    // offer one edge event after a random gap and hold it until taken;
    // valid stays high into the next item when that one has no gap
    task automatic send_event(input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] cap,
                              input logic pin);
        int gap;
        gap = in_idle ? $urandom_range(5, 0) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.channel       <= ch;
        in_if.capture_value <= cap;
        in_if.pin_level     <= pin;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_event(ch, cap, pin);
    endtask

    // a well-formed pulse: rising edge then falling edge a chosen width later
    task automatic send_pulse(input logic [CH_W-1:0] ch, input logic [CNT_W-1:0] start,
                              input logic [CNT_W-1:0] w);
        send_event(ch, start, 1'b1);
        send_event(ch, start + w, 1'b0);
    endtask

    // stop offering and let every pending result come back
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_readings.size() != 0);
    endtask

    // write all four thresholds back to back, only while the block is idle
    task automatic write_config(input logic [CFG_DATA_W-1:0] vals [4]);
        t_cfg_idx idx;
        for (int k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= vals[k];
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
            sb.write_reg(idx, vals[k]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // widths aimed at the current thresholds so the gestures actually fire
    function automatic logic [CNT_W-1:0] pick_width();
        int lo;
        int hi;
        case ($urandom_range(9, 0))
            0: begin
                // inside the arm band
                lo = int'(sb.cfg_reg[CFG_THROTTLE_ARM_MIN]) + 1;
                hi = int'(sb.cfg_reg[CFG_STICK_LOW_MAX]) - 1;
            end
            1: begin
                // inside the offset band
                lo = int'(sb.cfg_reg[CFG_THROTTLE_OFFSET_MIN]) + 1;
                hi = int'(sb.cfg_reg[CFG_STICK_LOW_MAX]) - 1;
            end
            2: begin
                // stick high
                lo = int'(sb.cfg_reg[CFG_STICK_HIGH_MIN]) + 1;
                hi = 65535;
            end
            3: begin
                // stick low
                lo = 0;
                hi = int'(sb.cfg_reg[CFG_STICK_LOW_MAX]) - 1;
            end
            4, 5, 6, 7: begin
                // on a threshold or one either side of it
                return sb.cfg_reg[t_cfg_idx'($urandom_range(3, 0))] +
                       CNT_W'($urandom_range(2, 0)) - CNT_W'(1);
            end
            8: return $urandom_range(1, 0) ? '1 : '0;
            default: return CNT_W'($urandom);
        endcase
        if (hi >= lo)
            return CNT_W'($urandom_range(hi, lo));
        return CNT_W'($urandom);
    endfunction

    // --------------------------------------------------------------------
    // result side: random stalls, one long hold-off on request
    // --------------------------------------------------------------------
    initial begin
        int stall;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = out_idle ? $urandom_range(5, 0) : 0;
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            sb.check_result(out_if.channel_echo, out_if.width_valid, out_if.pulse_width,
                            out_if.armed, out_if.offset_request);
        end
    end

    // --------------------------------------------------------------------
    // stimulus
    // --------------------------------------------------------------------
    initial begin
        logic [CFG_DATA_W-1:0] next_cfg [4];
        logic [CH_W-1:0]       ch;
        logic [CNT_W-1:0]      start;
        int                    done;
        int                    sel;
        int                    arm_v;
        int                    low_v;
        bit                    paused;

        sb = new();
        i_rst_n             <= 1'b0;
        in_if.valid         <= 1'b0;
        in_if.channel       <= '0;
        in_if.capture_value <= '0;
        in_if.pin_level     <= 1'b1;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= CFG_THROTTLE_ARM_MIN;
        cfg_if.data         <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, thresholds at their reset values
        send_event(CH_W'(CH_ROLL), 16'h0000, 1'b0);      // equal to reset edge time: width 0
        send_event(CH_W'(CH_PITCH), 16'hffff, 1'b1);     // rising at counter top
        send_event(CH_W'(CH_PITCH), 16'h0010, 1'b0);     // width across the wrap
        send_event(CH_W'(CH_THROTTLE), 16'h1234, 1'b1);
        send_event(CH_W'(CH_THROTTLE), 16'h1234, 1'b0);  // same capture twice: width 0
        send_event(CH_W'(3), 16'h0001, 1'b1);
        send_event(CH_W'(3), 16'h0000, 1'b0);            // largest width
        send_event(CH_W'(4), 16'd100, 1'b1);
        send_event(CH_W'(4), 16'd1600, 1'b0);
        send_event(CH_W'(5), 16'hffff, 1'b0);            // channels past the last are ignored
        send_event(CH_W'(6), 16'h0000, 1'b1);
        send_event(CH_W'(7), 16'haaaa, 1'b0);
        send_pulse(CH_W'(CH_THROTTLE), 16'd1000, 16'd8100);   // sticks low: arm
        send_pulse(CH_W'(CH_THROTTLE), 16'd2000, 16'd8250);   // throttle in offset band
        send_pulse(CH_W'(CH_ROLL), 16'h5555, 16'd15000);      // roll high: disarm
        send_pulse(CH_W'(CH_PITCH), 16'h7777, 16'd15000);     // roll and pitch high: offset
        send_event(CH_W'(4), 16'hffff, 1'b1);
        send_event(CH_W'(4), 16'hffff, 1'b0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            // every phase after the first starts from an idle block
            if (phase > 0) begin
                wait_drained();
                arm_v = $urandom_range(9000, 7000);
                low_v = $urandom_range(arm_v + 2000, arm_v + 100);
                case (phase)
                    1: next_cfg = '{16'd0, 16'd0, 16'd0, 16'd0};
                    2: next_cfg = '{16'hffff, 16'hffff, 16'hffff, 16'hffff};
                    3: next_cfg = '{16'd0, 16'd0, 16'hffff, 16'd0};
                    5: next_cfg = '{16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom)};
                    7: next_cfg = '{RST_THROTTLE_ARM_MIN, RST_THROTTLE_OFFSET_MIN,
                                    RST_STICK_LOW_MAX, RST_STICK_HIGH_MIN};
                    default: next_cfg = '{16'(arm_v), 16'($urandom_range(low_v - 1, arm_v)),
                                          16'(low_v), 16'($urandom_range(16000, 13000))};
                endcase
                write_config(next_cfg);
            end
            in_idle  = (phase % 3) != 1;
            out_idle = (phase % 4) != 2;
            // once the result side stops for a long stretch while events keep coming
            if (phase == 4)
                hold_req = 1'b1;

            done   = 0;
            paused = 1'b0;
            while (done < PHASE_ITEMS) begin
                sel = $urandom_range(99, 0);
                if (sel < 70) begin
                    // mostly complete pulses on the gesture channels
                    ch    = ($urandom_range(99, 0) < 85) ? CH_W'($urandom_range(2, 0))
                                                         : CH_W'($urandom_range(4, 3));
                    start = CNT_W'($urandom);
                    send_pulse(ch, start, pick_width());
                    done += 2;
                end else if (sel < 80) begin
                    // lone falling edge, measured from whatever edge came last
                    send_event(CH_W'($urandom_range(NCH - 1, 0)), CNT_W'($urandom), 1'b0);
                    done++;
                end else if (sel < 88) begin
                    // lone rising edge
                    send_event(CH_W'($urandom_range(NCH - 1, 0)), CNT_W'($urandom), 1'b1);
                    done++;
                end else begin
                    // raw noise over the whole field range
                    ch = CH_W'($urandom);
                    send_event(ch, CNT_W'($urandom), 1'($urandom));
                    if (ch < NCH)
                        done++;
                end
                // sender pause in the middle of a phase
                if (phase == 5 && !paused && done >= PHASE_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_readings.size() == 0)
            $display("rc_pwm_capture_arming: match");
        else
            $display("rc_pwm_capture_arming: mismatch");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("rc_pwm_capture_arming: mismatch");
        $finish;
    end

endmodule

FILE: rc_pwm_capture_arming.f
hdl/rcpa_pkg.sv
hdl/rcpa_in_if.sv
hdl/rcpa_out_if.sv
hdl/rcpa_cfg_if.sv
hdl/rc_pwm_capture_arming.sv
bench/rc_pwm_capture_arming_tb.sv
